/* hw/rtl/assert_macros.svh */
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every rising edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Expression that must never be true at a rising edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
  `ASSERT_PROP(label, clk, rst_n, !(expr), msg)

`endif

/* hw/rtl/crcaf_pkg.sv */
// Package with the types, constants and CRC update function of the CRC append formatter.
package crcaf_pkg;

  localparam int unsigned CRC_W     = 32;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned CRC_BYTES = CRC_W / BYTE_W;
  localparam int unsigned CFG_IDX_W = 1;

  typedef logic [CRC_W-1:0]  crc_t;
  typedef logic [BYTE_W-1:0] byte_t;

  localparam crc_t CRC_INIT    = 32'hFFFF_FFFF;
  localparam crc_t CRC_XOR_OUT = 32'hFFFF_FFFF;
  localparam crc_t POLY_RESET  = 32'h0000_00D8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POLYNOMIAL = 1'b0,
    REG_BYTE_ORDER = 1'b1
  } cfg_reg_t;

  // One accepted input beat together with what the appender needs from it.
  typedef struct packed {
    byte_t data_byte;
    logic  last_byte;
    crc_t  crc_final;
    logic  byte_order;
  } crcaf_beat_t;

  // Eight MSB-first shift-and-xor steps over one byte.
  function automatic crc_t crc_update(crc_t rem, byte_t data, crc_t poly);
    crc_t r;
    r = rem ^ {data, {(CRC_W-BYTE_W){1'b0}}};
    for (int i = 0; i < BYTE_W; i++) begin
      if (r[CRC_W-1]) begin
        r = {r[CRC_W-2:0], 1'b0} ^ poly;
      end else begin
        r = {r[CRC_W-2:0], 1'b0};
      end
    end
    return r;
  endfunction

endpackage

/* hw/rtl/crcaf_engine.sv */
// CRC remainder register and its byte-wide update network.
module crcaf_engine (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           accept,
  input  crcaf_pkg::byte_t data_byte,
  input  logic           last_byte,
  input  crcaf_pkg::crc_t  polynomial,
  output crcaf_pkg::crc_t  crc_final
);
  import crcaf_pkg::*;

  crc_t crc_r;
  crc_t crc_nxt;
  crc_t crc_upd;

  assign crc_upd   = crc_update(crc_r, data_byte, polynomial);
  assign crc_final = crc_upd ^ CRC_XOR_OUT;

  always_comb begin
    crc_nxt = crc_r;
    if (accept) begin
      // The remainder restarts once a message is closed.
      crc_nxt = last_byte ? CRC_INIT : crc_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= CRC_INIT;
    end else begin
      crc_r <= crc_nxt;
    end
  end

endmodule

/* hw/rtl/crcaf_emitter.sv */
// Output register and the sequencer that appends the four CRC bytes.
module crcaf_emitter (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  accept,
  input  crcaf_pkg::crcaf_beat_t beat,
  output logic                  take_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  output crcaf_pkg::byte_t      out_out_byte,
  output logic                  out_is_last
);
  import crcaf_pkg::*;

  localparam int unsigned CNT_W = $clog2(CRC_BYTES + 1);

  logic             out_valid_r, out_valid_nxt;
  byte_t            out_byte_r, out_byte_nxt;
  logic             out_last_r, out_last_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  crc_t             hold_r, hold_nxt;
  logic             load;

  assign load       = !out_valid_r || out_ready;
  assign take_ready = load && (cnt_r == '0);

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    cnt_nxt       = cnt_r;
    hold_nxt      = hold_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = beat.data_byte;
      out_last_nxt  = 1'b0;
      if (beat.last_byte) begin
        cnt_nxt = CNT_W'(CRC_BYTES);
        // The hold register always shifts out its top byte, so the low-first
        // order is stored byte-swapped.
        hold_nxt = beat.byte_order ? beat.crc_final :
                   {beat.crc_final[7:0], beat.crc_final[15:8],
                    beat.crc_final[23:16], beat.crc_final[31:24]};
      end
    end else if (load && (cnt_r != '0)) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = hold_r[CRC_W-1 -: BYTE_W];
      out_last_nxt  = (cnt_r == CNT_W'(1));
      cnt_nxt       = cnt_r - CNT_W'(1);
      hold_nxt      = {hold_r[CRC_W-BYTE_W-1:0], {BYTE_W{1'b0}}};
    end else if (load) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
    hold_r     <= hold_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_out_byte = out_byte_r;
  assign out_is_last  = out_last_r;

endmodule

/* hw/rtl/crc32_append_formatter.sv */
// Top level of the CRC-32 append formatter: configuration registers and wiring.
//
// Message bytes enter on the in_ channel (valid/ready) with a last flag and
// leave unchanged on the out_ channel in the cycle after the accepting edge.
// A 32-bit MSB-first CRC, starting at all ones, runs over every byte; the
// whole byte update is one xor network in front of the CRC register.
// After a byte marked last, four more beats carry the CRC xor all ones,
// high byte first or low byte first as byte_order selects; out_is_last
// marks the fourth. The remainder then restarts at all ones.
// One byte per cycle passes while out_ready is high and no CRC beats are
// pending; in_ready is low while the four CRC beats are sent.
// The cfg_ port writes polynomial (index 0) and byte_order (index 1);
// write only while the block is idle.
// Reset (rst_n low, synchronous) clears the CRC to all ones, the registers to
// polynomial 0xD8 and byte_order 0, and empties the output register.
// When out_ready is low the held beat stays put and in_ready drops until the
// output register can take a new beat.
module crc32_append_formatter (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  crcaf_pkg::byte_t              in_data_byte,
  input  logic                          in_last_byte,
  output logic                          out_valid,
  input  logic                          out_ready,
  output crcaf_pkg::byte_t              out_out_byte,
  output logic                          out_is_last,
  input  logic                          cfg_we,
  input  logic [crcaf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  crcaf_pkg::crc_t               cfg_wdata
);
  import crcaf_pkg::*;

  crc_t        poly_r;
  logic        order_r;
  logic        accept;
  logic        take_ready;
  crc_t        crc_final;
  crcaf_beat_t beat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      poly_r  <= POLY_RESET;
      order_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_POLYNOMIAL: poly_r  <= cfg_wdata;
        REG_BYTE_ORDER: order_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign in_ready = take_ready;
  assign accept   = in_valid && take_ready;

  crcaf_engine u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .data_byte  (in_data_byte),
    .last_byte  (in_last_byte),
    .polynomial (poly_r),
    .crc_final  (crc_final)
  );

  assign beat.data_byte  = in_data_byte;
  assign beat.last_byte  = in_last_byte;
  assign beat.crc_final  = crc_final;
  assign beat.byte_order = order_r;

  crcaf_emitter u_emitter (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .beat         (beat),
    .take_ready   (take_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_out_byte (out_out_byte),
    .out_is_last  (out_is_last)
  );

endmodule

/* hw/rtl/crcaf_checker.sv */
// Port-level assertions for the CRC append formatter and their bind.
`include "assert_macros.svh"

module crcaf_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_ready,
  input crcaf_pkg::byte_t              in_data_byte,
  input logic                          in_last_byte,
  input logic                          out_valid,
  input logic                          out_ready,
  input crcaf_pkg::byte_t              out_out_byte,
  input logic                          out_is_last
);

  // A stalled output beat must hold its payload.
  `ASSERT_PROP(a_out_hold, clk, rst_n, (out_valid && !out_ready) |=> (out_valid && $stable(out_out_byte) && $stable(out_is_last)), "stalled output beat changed")

  // Every accepted byte appears on the output in the next cycle, never marked last.
  `ASSERT_PROP(a_pass_through, clk, rst_n, (in_valid && in_ready) |=> (out_valid && !out_is_last && (out_out_byte == $past(in_data_byte))), "accepted byte not passed through")

  // The cycle after a closing byte, the input waits for the CRC beats.
  `ASSERT_NEVER(a_append_blocks, clk, rst_n, $past(in_valid && in_ready && in_last_byte) && in_ready, "input taken while CRC bytes pending")

  // The final CRC beat cannot follow directly on a closing byte.
  `ASSERT_NEVER(a_last_spacing, clk, rst_n, $past(in_valid && in_ready && in_last_byte) && out_is_last, "final CRC beat too early")

endmodule

bind crc32_append_formatter crcaf_checker u_crcaf_checker (.*);

/* tb/crcaf_stream_checker.sv */
// Checker for the CRC append formatter: predicts the output byte stream and compares each beat.
module crcaf_stream_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  crcaf_pkg::byte_t                in_data_byte,
  input  logic                            in_last_byte,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  crcaf_pkg::byte_t                out_out_byte,
  input  logic                            out_is_last,
  input  logic                            cfg_we,
  input  logic [crcaf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  crcaf_pkg::crc_t                 cfg_wdata,
  output int unsigned                     fail_count,
  output int unsigned                     pending
);
  import crcaf_pkg::*;

  localparam int unsigned MAX_REPORTS = 10;

  typedef struct packed {
    byte_t out_byte;
    logic  is_last;
  } out_beat_t;

  crc_t      model_poly;
  logic      model_high_first;
  crc_t      running_crc;
  out_beat_t expected_beats[$];

  // Bit-serial form: each message bit is folded into the top of the remainder in turn.
  function automatic crc_t fold_byte(crc_t rem, byte_t b, crc_t poly);
    crc_t r;
    logic top;
    r = rem;
    for (int k = BYTE_W - 1; k >= 0; k--) begin
      top = r[CRC_W-1] ^ b[k];
      r = r << 1;
      if (top) begin
        r = r ^ poly;
      end
    end
    return r;
  endfunction

  task automatic queue_expected_beats(input byte_t b, input logic last);
    crc_t      crc_out;
    out_beat_t beat;
    int unsigned shift;
    running_crc = fold_byte(running_crc, b, model_poly);
    beat.out_byte = b;
    beat.is_last = 1'b0;
    expected_beats.push_back(beat);
    if (last) begin
      crc_out = running_crc ^ CRC_XOR_OUT;
      for (int k = 0; k < CRC_BYTES; k++) begin
        shift = model_high_first ? (CRC_W - BYTE_W) - BYTE_W * k : BYTE_W * k;
        beat.out_byte = byte_t'(crc_out >> shift);
        beat.is_last = (k == CRC_BYTES - 1);
        expected_beats.push_back(beat);
      end
      running_crc = CRC_INIT;
    end
  endtask

  task automatic note_failure(input string what, input out_beat_t exp_beat);
    fail_count++;
    if (fail_count <= MAX_REPORTS) begin
      $display("MISMATCH %s: expected byte %02h last %b, got byte %02h last %b",
               what, exp_beat.out_byte, exp_beat.is_last, out_out_byte, out_is_last);
    end
  endtask

  always @(posedge clk) begin : monitor
    out_beat_t exp_beat;
    if (!rst_n) begin
      model_poly = POLY_RESET;
      model_high_first = 1'b0;
      running_crc = CRC_INIT;
      expected_beats.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_POLYNOMIAL: model_poly = cfg_wdata;
          REG_BYTE_ORDER: model_high_first = cfg_wdata[0];
          default: ;
        endcase
      end
      // The input side goes first so that a same-edge pass-through would still line up.
      if (in_valid && in_ready) begin
        queue_expected_beats(in_data_byte, in_last_byte);
      end
      if (out_valid && out_ready) begin
        if (expected_beats.size() == 0) begin
          exp_beat = '0;
          note_failure("unexpected beat", exp_beat);
        end else begin
          exp_beat = expected_beats.pop_front();
          if (exp_beat.out_byte !== out_out_byte) begin
            note_failure("out_byte", exp_beat);
          end
          if (exp_beat.is_last !== out_is_last) begin
            note_failure("is_last", exp_beat);
          end
        end
      end
    end
    pending = expected_beats.size();
  end

endmodule

/* tb/tb_crc32_append_formatter.sv */
// Testbench top for the CRC append formatter: clock, reset, stimulus, stalls and verdict.
module tb_crc32_append_formatter;
  import crcaf_pkg::*;

  localparam int unsigned RX_HOLD_CYCLES = 300;
  localparam int unsigned WATCHDOG_LIMIT = 3000;

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_ready;
  byte_t                   in_data_byte;
  logic                    in_last_byte;
  logic                    out_valid;
  logic                    out_ready;
  byte_t                   out_out_byte;
  logic                    out_is_last;
  logic                    cfg_we;
  logic [CFG_IDX_W-1:0]    cfg_index;
  crc_t                    cfg_wdata;
  int unsigned             fail_count;
  int unsigned             pending;

  int unsigned             msg_left;
  bit                      hold_req;
  bit                      hold_done;
  int unsigned             idle_cycles;

  crc32_append_formatter dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_out_byte (out_out_byte),
    .out_is_last  (out_is_last),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  crcaf_stream_checker stream_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .in_last_byte (in_last_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_out_byte (out_out_byte),
    .out_is_last  (out_is_last),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Mostly short gaps, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic int unsigned pick_msg_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 6);
    if (r < 95) return $urandom_range(7, 20);
    return $urandom_range(21, 64);
  endfunction

  task automatic send_byte(input byte_t b, input logic last, input int unsigned gap);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      in_data_byte <= byte_t'($urandom);
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_last_byte <= last;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stop offering and wait until every predicted beat has left the block.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input crc_t value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
  endtask

  task automatic configure(input crc_t poly, input logic high_first);
    write_reg(REG_POLYNOMIAL, poly);
    write_reg(REG_BYTE_ORDER, crc_t'(high_first));
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // A phase may end in the middle of a message; the next one finishes it
  // under the new polynomial.
  task automatic run_phase(input crc_t poly, input logic high_first, input int unsigned n,
                           input bit gaps_on);
    logic last;
    drain();
    configure(poly, high_first);
    for (int i = 0; i < n; i++) begin
      if (msg_left == 0) begin
        msg_left = pick_msg_len();
      end
      msg_left--;
      last = (msg_left == 0);
      send_byte(byte_t'($urandom_range(0, 255)), last, gaps_on ? pick_gap() : 0);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data_byte = '0;
    in_last_byte = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_POLYNOMIAL;
    cfg_wdata = '0;
    msg_left = 0;
    hold_req = 1'b0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // Single-byte messages at the field extremes, then a two-byte message, with the reset settings.
    send_byte(8'h00, 1'b1, 0);
    send_byte(8'hFF, 1'b1, 0);
    send_byte(8'hA5, 1'b0, 0);
    send_byte(8'h5A, 1'b1, 1);

    // The standard generator over the usual check string, high byte first, then a three-byte message.
    drain();
    configure(32'h04C1_1DB7, 1'b1);
    for (int i = 0; i < 9; i++) begin
      send_byte(byte_t'(8'h31 + i), i == 8, 0);
    end
    send_byte(8'h80, 1'b0, 2);
    send_byte(8'h01, 1'b0, 0);
    send_byte(8'h7F, 1'b1, 0);

    run_phase(POLY_RESET, 1'b0, 28, 1'b1);
    // Empty the block first so that the hold-off lands on a sender that keeps offering.
    drain();
    hold_req = 1'b1;
    run_phase(32'h04C1_1DB7, 1'b1, 28, 1'b1);
    run_phase(32'h0000_0000, 1'b0, 24, 1'b0);
    run_phase(32'hFFFF_FFFF, 1'b1, 24, 1'b1);
    run_phase(crc_t'($urandom), logic'($urandom_range(0, 1)), 28, 1'b1);
    run_phase(crc_t'($urandom), logic'($urandom_range(0, 1)), 28, 1'b1);

    drain();
    repeat (8) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_crc32_append_formatter passed");
    end else begin
      $display("tb_crc32_append_formatter failed");
    end
    $finish;
  end

  // Receiver: random stalls, ready stretches, and one long hold-off.
  initial begin : receiver
    int unsigned stall_left;
    int unsigned hold_count;
    int unsigned rx_cycle;
    out_ready = 1'b0;
    hold_done = 1'b0;
    stall_left = 0;
    hold_count = 0;
    rx_cycle = 0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      rx_cycle++;
      if (hold_req && !hold_done) begin
        out_ready <= 1'b0;
        hold_count++;
        if (hold_count == RX_HOLD_CYCLES) begin
          hold_done = 1'b1;
        end
      end else if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left--;
      end else begin
        out_ready <= 1'b1;
        if ((rx_cycle % 200) >= 40) begin
          stall_left = pick_gap();
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
    end else begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Timeout: no beat moved for %0d cycles", idle_cycles);
        $display("tb_crc32_append_formatter failed");
        $finish;
      end
    end
  end

endmodule
